// ===== hw/rtl/xpd_pkg.sv =====
package xpd_pkg;

    // Parser phases; the value is reported as parse_phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_N     = 3'd1,
        PH_E     = 3'd2,
        PH_R     = 3'd3,
        PH_LEN   = 3'd4,
        PH_COLON = 3'd5,
        PH_BODY  = 3'd6
    } xpd_phase_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } xpd_op_t;

    // Header bytes
    localparam logic [7:0] HDR_U     = 8'h55;
    localparam logic [7:0] HDR_N     = 8'h4E;
    localparam logic [7:0] HDR_E     = 8'h45;
    localparam logic [7:0] HDR_R     = 8'h52;
    localparam logic [7:0] HDR_COLON = 8'h3A;

    localparam logic [2:0] TIMEOUT_TICKS = 3'd5;

    // One word taken from the input side
    typedef struct packed {
        xpd_op_t    op;
        logic [7:0] rx_byte;
    } xpd_item_t;

    // One result word
    typedef struct packed {
        logic       frame_good;
        logic       frame_bad;
        logic [7:0] data_index;
        logic [2:0] parse_phase;
    } xpd_result_t;

    // Byte expected in a fixed-header phase
    function automatic logic [7:0] hdr_expected(input xpd_phase_t ph);
        logic [7:0] b;
        unique case (ph)
            PH_N:     b = HDR_N;
            PH_E:     b = HDR_E;
            PH_R:     b = HDR_R;
            PH_COLON: b = HDR_COLON;
            default:  b = HDR_U;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/xor_packet_deframer_core.sv =====
// Path: an accepted input word passes through the input register, then the result
// register, before its result word is shown on out_valid.
// Throughput: one word per cycle, sustained while out_ready stays high; the per-word parser update is a single
// combinational step between the input register and the result register.
// Reset: rst_n is asynchronous, active low; it empties both registers and returns the
// parser to idle with checksum, length, positions and timeout cleared.
module xor_packet_deframer_core
    import xpd_pkg::*;
#(
    parameter int RING_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_good,
    output logic       frame_bad,
    output logic [7:0] data_index,
    output logic [2:0] parse_phase
);

    // Input register: holds one accepted word until the parser takes it
    logic        in_vld_reg;
    xpd_item_t   item_reg;

    // Result register
    logic        out_vld_reg;
    xpd_result_t res_reg;

    xpd_result_t res_next;
    logic        step_en;

    // The parser steps whenever a word sits in the input register and the
    // result register is free or being drained this cycle.
    assign step_en  = in_vld_reg && (!out_vld_reg || out_ready);
    // A new word enters when the input register is empty or moves on now.
    assign in_ready = !in_vld_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.op      <= xpd_op_t'(operation);
            item_reg.rx_byte <= rx_byte;
        end
    end

    xpd_parser #(
        .RING_SIZE (RING_SIZE)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign frame_good  = res_reg.frame_good;
    assign frame_bad   = res_reg.frame_bad;
    assign data_index  = res_reg.data_index;
    assign parse_phase = res_reg.parse_phase;

endmodule

// ===== hw/rtl/xpd_parser.sv =====
module xpd_parser
    import xpd_pkg::*;
#(
    parameter int RING_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  xpd_item_t   item,
    output xpd_result_t result
);

    localparam logic [8:0] RING_LIM = 9'(RING_SIZE);

    xpd_phase_t phase_reg, phase_next;
    logic [7:0] csum_reg, csum_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] pos_reg, pos_next;
    logic [2:0] ticks_reg, ticks_next;

    logic [8:0] pos_inc;
    logic [8:0] pos_inc2;
    logic [7:0] left_dec;
    logic       body_end;

    assign pos_inc  = {1'b0, pos_reg} + 9'd1;
    assign pos_inc2 = {1'b0, pos_reg} + 9'd2;
    assign left_dec = left_reg - 8'd1;
    assign body_end = (phase_reg == PH_BODY) && (left_dec == 8'd0);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        csum_next  = csum_reg;
        left_next  = left_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        ticks_next = ticks_reg;
        if (item.op == OP_TICK)
        begin
            if (ticks_reg != 3'd0)
            begin
                ticks_next = ticks_reg - 3'd1;
                if (ticks_reg == 3'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
        else
        begin
            pos_next = (pos_inc >= RING_LIM) ? 8'd0 : pos_inc[7:0];
            unique case (phase_reg)
                PH_IDLE, PH_N, PH_E, PH_R, PH_COLON:
                begin
                    if (phase_reg != PH_IDLE && item.rx_byte == hdr_expected(phase_reg))
                    begin
                        csum_next  = csum_reg ^ item.rx_byte;
                        phase_next = xpd_phase_t'(phase_reg + 3'd1);
                    end
                    else if (item.rx_byte == HDR_U)
                    begin
                        // idle, or a header mismatch re-checked as a frame start
                        phase_next = PH_N;
                        ticks_next = TIMEOUT_TICKS;
                        csum_next  = item.rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    csum_next  = csum_reg ^ item.rx_byte;
                    left_next  = item.rx_byte;
                    start_next = (pos_inc2 >= RING_LIM) ? 8'(pos_inc2 - RING_LIM)
                                                        : pos_inc2[7:0];
                    phase_next = PH_COLON;
                end
                PH_BODY:
                begin
                    left_next = left_dec;
                    if (body_end)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        csum_next = csum_reg ^ item.rx_byte;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        result.frame_good  = (item.op == OP_BYTE) && body_end && (item.rx_byte == csum_reg);
        result.frame_bad   = (item.op == OP_BYTE) && body_end && (item.rx_byte != csum_reg);
        result.data_index  = start_next;
        result.parse_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            csum_reg  <= 8'd0;
            left_reg  <= 8'd0;
            start_reg <= 8'd0;
            pos_reg   <= 8'd0;
            ticks_reg <= 3'd0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            csum_reg  <= csum_next;
            left_reg  <= left_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import xpd_pkg::*;

    localparam int RING_SIZE    = 256;
    localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 8;    // drains the input and result registers, plus margin
    localparam int STALL_LIMIT  = 500;  // cycles with no word moving on either side

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       operation;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       frame_good;
    logic       frame_bad;
    logic [7:0] data_index;
    logic [2:0] parse_phase;

    // Parser state mirror
    xpd_phase_t ph;
    logic [7:0] csum;
    logic [7:0] len_left;
    logic [7:0] cmd_pos;
    logic [7:0] rx_pos;
    logic [2:0] tmo_left;

    xpd_result_t pending_results[$];
    int          err_cnt;
    int          words_sent;
    int          quiet_cycles;
    bit          in_gaps;
    bit          out_gaps;
    bit          hold_req;

    xor_packet_deframer_core #(
        .RING_SIZE(RING_SIZE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_good (frame_good),
        .frame_bad  (frame_bad),
        .data_index (data_index),
        .parse_phase(parse_phase)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One parser update per accepted word; returns the result word it causes.
    function automatic xpd_result_t parse_step(input xpd_op_t op, input logic [7:0] b);
        xpd_result_t r;
        logic        rescan;
        logic [7:0]  want;
        r = '0;
        if (op == OP_TICK)
        begin
            // tick with timeout already expired is a no-op
            if (tmo_left != 3'd0)
            begin
                tmo_left = tmo_left - 3'd1;
                if (tmo_left == 3'd0)
                    ph = PH_IDLE;
            end
        end
        else
        begin
            rescan = 1'b1;
            while (rescan)
            begin
                rescan = 1'b0;
                case (ph)
                    PH_IDLE:
                    begin
                        if (b == HDR_U)
                        begin
                            ph       = PH_N;
                            tmo_left = TIMEOUT_TICKS;
                            csum     = b;
                        end
                    end
                    PH_N, PH_E, PH_R, PH_COLON:
                    begin
                        case (ph)
                            PH_N:    want = HDR_N;
                            PH_E:    want = HDR_E;
                            PH_R:    want = HDR_R;
                            default: want = HDR_COLON;
                        endcase
                        if (b == want)
                        begin
                            csum = csum ^ b;
                            ph   = xpd_phase_t'(ph + 3'd1);
                        end
                        else
                        begin
                            // header broken: same byte gets a second look as a 'U'
                            ph     = PH_IDLE;
                            rescan = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        csum     = csum ^ b;
                        len_left = b;
                        cmd_pos  = 8'((int'(rx_pos) + 2) % RING_SIZE);
                        ph       = PH_COLON;
                    end
                    PH_BODY:
                    begin
                        // 8-bit wrap: length 0 means 256 body bytes
                        len_left = len_left - 8'd1;
                        if (len_left != 8'd0)
                            csum = csum ^ b;
                        else
                        begin
                            ph = PH_IDLE;
                            if (b == csum)
                                r.frame_good = 1'b1;
                            else
                                r.frame_bad = 1'b1;
                        end
                    end
                    default:
                        ph = PH_IDLE;
                endcase
            end
            rx_pos = 8'((int'(rx_pos) + 1) % RING_SIZE);
        end
        r.data_index  = cmd_pos;
        r.parse_phase = ph;
        return r;
    endfunction

    // Offer one word; returns at the edge that takes it, valid still high.
    task automatic send_word(input xpd_op_t op, input logic [7:0] b);
        bit taken;
        int gap;
        if (in_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_results.push_back(parse_step(op, b));
        words_sent++;
    endtask

    // Full frame; the last body byte carries the XOR of all earlier bytes, corrupted when bad_sum is set.
    task automatic send_frame(input logic [7:0] len, input bit bad_sum, input int tick_pct);
        logic [7:0] sum;
        logic [7:0] b;
        int         body_n;
        body_n = (len == 8'd0) ? 256 : int'(len);
        sum    = HDR_U ^ HDR_N ^ HDR_E ^ HDR_R ^ len ^ HDR_COLON;
        send_word(OP_BYTE, HDR_U);
        send_word(OP_BYTE, HDR_N);
        send_word(OP_BYTE, HDR_E);
        send_word(OP_BYTE, HDR_R);
        send_word(OP_BYTE, len);
        send_word(OP_BYTE, HDR_COLON);
        for (int i = 0; i < body_n - 1; i++)
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            if ($urandom_range(0, 99) < tick_pct)
                send_word(OP_TICK, 8'($urandom));
            send_word(OP_BYTE, b);
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_word(OP_BYTE, sum);
    endtask

    task automatic test_timeout();
        send_word(OP_TICK, 8'hFF);      // timer not armed yet
        send_word(OP_BYTE, HDR_U);
        repeat (5) send_word(OP_TICK, 8'($urandom));
    endtask

    task automatic test_good_frame();
        send_frame(8'd1, 1'b0, 0);      // body is the checksum byte alone
    endtask

    task automatic test_header_restart();
        send_word(OP_BYTE, HDR_U);
        send_word(OP_BYTE, HDR_U);      // mismatch on 'N', restarts as a new 'U'
        send_word(OP_BYTE, HDR_N);
        send_word(OP_BYTE, HDR_E);
        send_word(OP_BYTE, HDR_R);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);      // not ':' and not 'U'
    endtask

    task automatic test_long_frames();
        send_frame(8'd0, 1'b0, 0);      // 256 body bytes
        send_frame(8'd255, 1'b1, 0);
    endtask

    task automatic test_random_traffic(input int n_words);
        int         stop_at;
        int         pick;
        int         k;
        logic [7:0] len;
        logic [7:0] seq [5];
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 40))
                                                  : 8'($urandom_range(1, 12));
                send_frame(len, $urandom_range(0, 3) == 0, 2);
            end
            else if (pick < 80)
            begin
                // header cut short, then one arbitrary byte
                seq[0] = HDR_U;
                seq[1] = HDR_N;
                seq[2] = HDR_E;
                seq[3] = HDR_R;
                seq[4] = 8'($urandom);
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++)
                    send_word(OP_BYTE, seq[i]);
                send_word(OP_BYTE, 8'($urandom));
            end
            else if (pick < 90)
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_word(OP_TICK, 8'($urandom));
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    case ($urandom_range(0, 7))
                        0:       len = HDR_U;
                        1:       len = HDR_N;
                        2:       len = HDR_E;
                        3:       len = HDR_R;
                        4:       len = HDR_COLON;
                        default: len = 8'($urandom);
                    endcase
                    send_word($urandom_range(0, 3) == 0 ? OP_TICK : OP_BYTE, len);
                end
            end
        end
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        send_frame(8'd12, 1'b0, 0);
        send_frame(8'd6, 1'b1, 0);
        in_valid <= 1'b0;
        wait (!hold_req);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin : result_sink
        int n;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (out_gaps && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Outputs are stable at the falling edge; a word seen here is taken at the next rise.
    always @(negedge clk)
    begin : check_results
        xpd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word: good=%0b bad=%0b index=%0d phase=%0d",
                         $time, frame_good, frame_bad, data_index, parse_phase);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (frame_good !== want.frame_good)
                begin
                    $display("%0t: frame_good expected %0b actual %0b",
                             $time, want.frame_good, frame_good);
                    err_cnt++;
                end
                if (frame_bad !== want.frame_bad)
                begin
                    $display("%0t: frame_bad expected %0b actual %0b",
                             $time, want.frame_bad, frame_bad);
                    err_cnt++;
                end
                if (data_index !== want.data_index)
                begin
                    $display("%0t: data_index expected %0d actual %0d",
                             $time, want.data_index, data_index);
                    err_cnt++;
                end
                if (parse_phase !== want.parse_phase)
                begin
                    $display("%0t: parse_phase expected %0d actual %0d",
                             $time, want.parse_phase, parse_phase);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, pending_results.size());
            $display("xor_packet_deframer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= OP_BYTE;
        rx_byte    <= 8'h00;
        ph          = PH_IDLE;
        csum        = 8'h00;
        len_left    = 8'h00;
        cmd_pos     = 8'h00;
        rx_pos      = 8'h00;
        tmo_left    = 3'd0;
        err_cnt     = 0;
        words_sent  = 0;
        quiet_cycles = 0;
        hold_req    = 1'b0;
        in_gaps     = 1'b1;
        out_gaps    = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_timeout();
        test_good_frame();
        test_header_restart();
        test_long_frames();
        test_random_traffic(450);
        test_output_stall();

        // closing stretch: back to back on both sides
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        @(posedge clk);
        test_random_traffic(200);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("xor_packet_deframer_core: match");
        else
            $display("xor_packet_deframer_core: mismatch");
        $finish;
    end

endmodule
